FILE: rtl/core/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  // Queue geometry
  localparam int CAPACITY  = 16;
  localparam int ID_BITS   = 16;
  localparam int PRIO_BITS = 8;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  // Field widths of the channels
  localparam int FUNC_W   = 1;
  localparam int STATUS_W = 2;

  // Function codes of an input beat
  localparam logic [FUNC_W-1:0] FUNC_ENQ = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Cell operation broadcast along the chain
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   entry;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/spq_if.sv
`timescale 1ns / 1ps

interface spq_in_if;
  logic                                valid;
  logic                                ready;
  logic [spq_pkg::FUNC_W-1:0]          func;
  logic [spq_pkg::ID_BITS-1:0]         entry_id;
  logic [spq_pkg::PRIO_BITS-1:0]       entry_priority;

  modport source (output valid, func, entry_id, entry_priority, input ready);
  modport sink   (input valid, func, entry_id, entry_priority, output ready);
endinterface

interface spq_out_if;
  logic                                valid;
  logic                                ready;
  logic [spq_pkg::STATUS_W-1:0]        status;
  logic [spq_pkg::ID_BITS-1:0]         out_id;
  logic [spq_pkg::PRIO_BITS-1:0]       out_priority;
  logic [spq_pkg::ID_BITS-1:0]         head_id;
  logic [spq_pkg::PRIO_BITS-1:0]       head_priority;
  logic [spq_pkg::ID_BITS-1:0]         tail_id;
  logic [spq_pkg::PRIO_BITS-1:0]       tail_priority;
  logic [spq_pkg::CNT_BITS-1:0]        count;
  logic                                is_empty;

  modport source (output valid, status, out_id, out_priority, head_id, head_priority,
                  tail_id, tail_priority, count, is_empty, input ready);
  modport sink   (input valid, status, out_id, out_priority, head_id, head_priority,
                  tail_id, tail_priority, count, is_empty, output ready);
endinterface

FILE: rtl/core/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,
  input  spq_pkg::entry_t     left_entry_i,
  input  logic                left_ge_i,
  input  spq_pkg::entry_t     right_entry_i,
  output spq_pkg::entry_t     entry_o,
  output logic                ge_o
);

  spq_pkg::entry_t entry_q;
  spq_pkg::entry_t entry_d;

  // Flag an occupied slot that ranks at or above the incoming entry
  assign ge_o    = occ_i && (entry_q.prio >= ctrl_i.entry.prio);
  assign entry_o = entry_q;

  // Keep, take the new entry, shift right on push, shift left on pop
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      spq_pkg::OP_PUSH: begin
        if (ge_o) begin
          entry_d = entry_q;
        end else if (left_ge_i) begin
          entry_d = ctrl_i.entry;
        end else begin
          entry_d = left_entry_i;
        end
      end
      spq_pkg::OP_POP: begin
        entry_d = right_entry_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

FILE: rtl/core/stable_priority_queue.sv
`timescale 1ns / 1ps
// Each result beat is registered and valid in the cycle after its input is taken.
// Throughput: one enqueue or dequeue per cycle unless an untaken result stalls;
// every cell of the chain loads its new slot in the same cycle, and the next beat
// is taken as the result leaves. Reset clears the entry count and the result
// valid; slot contents are not cleared and never shown before they are written.
module stable_priority_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  localparam int CAP = spq_pkg::CAPACITY;

  spq_pkg::cell_ctrl_t                ctrl;
  spq_pkg::entry_t                    cell_entry [CAP];
  logic [CAP-1:0]                     cell_ge;
  logic [CAP-1:0]                     cell_occ;
  logic [CAP-1:0]                     cell_tail;

  logic [spq_pkg::CNT_BITS-1:0]       count_q;
  logic [spq_pkg::CNT_BITS-1:0]       count_d;
  logic                               out_valid_q;
  spq_pkg::status_e                   status_q;
  spq_pkg::status_e                   status_d;
  spq_pkg::entry_t                    out_entry_q;
  spq_pkg::entry_t                    out_entry_d;
  spq_pkg::entry_t                    tail_entry;
  logic                               in_fire;
  logic                               is_full;
  logic                               is_empty;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign is_full    = (count_q == spq_pkg::CNT_BITS'(CAP));
  assign is_empty   = (count_q == '0);

  // Decode the beat into a chain operation, status and next count
  always_comb begin
    ctrl.op          = spq_pkg::OP_HOLD;
    ctrl.entry.id    = in_i.entry_id;
    ctrl.entry.prio  = in_i.entry_priority;
    status_d         = spq_pkg::STATUS_DONE;
    out_entry_d      = '0;
    count_d          = count_q;
    if (in_i.func == spq_pkg::FUNC_DEQ) begin
      if (is_empty) begin
        status_d = spq_pkg::STATUS_EMPTY;
      end else begin
        ctrl.op     = in_fire ? spq_pkg::OP_POP : spq_pkg::OP_HOLD;
        out_entry_d = cell_entry[0];
        count_d     = count_q - 1'b1;
      end
    end else begin
      if (is_full) begin
        status_d = spq_pkg::STATUS_FULL;
      end else begin
        ctrl.op = in_fire ? spq_pkg::OP_PUSH : spq_pkg::OP_HOLD;
        count_d = count_q + 1'b1;
      end
    end
  end

  // Chain of slot cells, head at index zero
  for (genvar k = 0; k < CAP; k++) begin : g_cell
    assign cell_occ[k]  = (count_q > spq_pkg::CNT_BITS'(k));
    assign cell_tail[k] = (count_q == spq_pkg::CNT_BITS'(k + 1));

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (cell_occ[k]),
      .left_entry_i  ((k == 0) ? ctrl.entry : cell_entry[(k == 0) ? 0 : k - 1]),
      .left_ge_i     ((k == 0) ? 1'b1 : cell_ge[(k == 0) ? 0 : k - 1]),
      .right_entry_i ((k == CAP - 1) ? cell_entry[k] : cell_entry[(k == CAP - 1) ? k : k + 1]),
      .entry_o       (cell_entry[k]),
      .ge_o          (cell_ge[k])
    );
  end

  // Pick the tail slot by its one-hot position
  always_comb begin
    tail_entry = '0;
    for (int k = 0; k < CAP; k++) begin
      tail_entry = tail_entry | (cell_tail[k] ? cell_entry[k] : '0);
    end
  end

  // Hold count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q <= count_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture status and dequeued entry of the beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q    <= status_d;
      out_entry_q <= out_entry_d;
    end
  end

  // Result fields reflect the queue as it stands after the beat
  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.out_id        = out_entry_q.id;
  assign out_o.out_priority  = out_entry_q.prio;
  assign out_o.head_id       = is_empty ? '0 : cell_entry[0].id;
  assign out_o.head_priority = is_empty ? '0 : cell_entry[0].prio;
  assign out_o.tail_id       = tail_entry.id;
  assign out_o.tail_priority = tail_entry.prio;
  assign out_o.count         = count_q;
  assign out_o.is_empty      = is_empty;

endmodule
